// ===== sv/nfcrp_pkg.sv =====
`default_nettype none

package nfcrp_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned TICK_W = 16;
    localparam int unsigned REQ_W = 2;
    localparam int unsigned KIND_W = 3;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 16;

    // request codes
    localparam logic [REQ_W-1:0] REQ_START = 2'd0;
    localparam logic [REQ_W-1:0] REQ_BYTE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_TICK = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HUNT_TIMEOUT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_MARKER = 2'd2;

    localparam logic [TICK_W-1:0] HUNT_TIMEOUT_RST = 16'd200;
    localparam logic [BYTE_W-1:0] MAX_PAYLOAD_RST = 8'd20;
    localparam logic [BYTE_W-1:0] START_MARKER_RST = 8'hFF;
    localparam logic [BYTE_W-1:0] HEADER_BYTES = 8'd2;
    localparam logic [TICK_W-1:0] TICK_MAX = 16'hFFFF;

    typedef enum logic [KIND_W-1:0] {
        KIND_NONE    = 3'd0,
        KIND_BYTE    = 3'd1,
        KIND_DONE    = 3'd2,
        KIND_LCS_ERR = 3'd3,
        KIND_TIMEOUT = 3'd4
    } t_kind;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_HUNT = 3'd1,
        PH_LEN  = 3'd2,
        PH_LCS  = 3'd3,
        PH_HDR  = 3'd4,
        PH_DATA = 3'd5,
        PH_TAIL = 3'd6
    } t_phase;

    typedef struct packed {
        logic [TICK_W-1:0] hunt_timeout;
        logic [BYTE_W-1:0] max_payload;
        logic [BYTE_W-1:0] start_marker;
    } t_cfg;

    typedef struct packed {
        t_kind             kind;
        logic [BYTE_W-1:0] payload_byte;
        logic [BYTE_W-1:0] payload_index;
        logic [BYTE_W-1:0] payload_count;
    } t_result;

    function automatic logic [BYTE_W-1:0] flip8(input logic [BYTE_W-1:0] v);
        logic [BYTE_W-1:0] r;
        for (int k = 0; k < BYTE_W; k++) begin
            r[k] = v[BYTE_W-1-k];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== sv/nfcrp_if.sv =====
`default_nettype none

interface nfcrp_item_if
    import nfcrp_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [REQ_W-1:0]  req_type;
    logic [BYTE_W-1:0] raw_byte;

    modport source (output valid, output req_type, output raw_byte, input ready);
    modport sink (input valid, input req_type, input raw_byte, output ready);
endinterface

interface nfcrp_result_if
    import nfcrp_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] payload_byte;
    logic [BYTE_W-1:0] payload_index;
    logic [BYTE_W-1:0] payload_count;

    modport source (
        output valid, output kind, output payload_byte, output payload_index,
        output payload_count, input ready
    );
    modport sink (
        input valid, input kind, input payload_byte, input payload_index,
        input payload_count, output ready
    );
endinterface

interface nfcrp_cfg_if
    import nfcrp_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/nfc_response_frame_parser_core.sv =====
// channel    | dir | transfer carries
// -----------+-----+----------------------------------------------------
// i_item     | in  | req_type, raw_byte (start / received byte / ms tick)
// o_res      | out | kind, payload_byte, payload_index, payload_count
// i_cfg      | in  | index, data (register write, always ready)
//
// one item per clock sustained while results are taken; each item gives exactly one result
// input transfer to result passes through the input register, then the result register
// the frame state updates as an item moves from the input register to the result register
// a stalled result register holds the next item in the input register; two in flight at most
// synchronous active-low reset returns the parser to idle and the registers to defaults

`default_nettype none

module nfc_response_frame_parser_core
    import nfcrp_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    nfcrp_item_if.sink      i_item,
    nfcrp_result_if.source  o_res,
    nfcrp_cfg_if.sink       i_cfg
);

    logic              r_in_valid;
    logic [REQ_W-1:0]  r_in_req;
    logic [BYTE_W-1:0] r_in_raw;
    logic              r_out_valid;
    t_result           r_out;
    t_cfg              r_cfg;
    t_result           step_res;
    logic              advance;

    assign advance      = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_item.ready = !r_in_valid || advance;
    assign i_cfg.ready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hunt_timeout <= HUNT_TIMEOUT_RST;
            r_cfg.max_payload  <= MAX_PAYLOAD_RST;
            r_cfg.start_marker <= START_MARKER_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_HUNT_TIMEOUT: r_cfg.hunt_timeout <= i_cfg.data;
                CFG_MAX_PAYLOAD:  r_cfg.max_payload  <= i_cfg.data[BYTE_W-1:0];
                CFG_START_MARKER: r_cfg.start_marker <= i_cfg.data[BYTE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_in_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.ready && i_item.valid) begin
            r_in_req <= i_item.req_type;
            r_in_raw <= i_item.raw_byte;
        end
    end

    nfcrp_fsm u_fsm (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_advance  (advance),
        .i_req_type (r_in_req),
        .i_raw_byte (r_in_raw),
        .i_cfg      (r_cfg),
        .o_result   (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= step_res;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.kind          = r_out.kind;
    assign o_res.payload_byte  = r_out.payload_byte;
    assign o_res.payload_index = r_out.payload_index;
    assign o_res.payload_count = r_out.payload_count;

endmodule

`default_nettype wire

// ===== sv/nfcrp_fsm.sv =====
`default_nettype none

module nfcrp_fsm
    import nfcrp_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_advance,
    input  wire logic [REQ_W-1:0]  i_req_type,
    input  wire logic [BYTE_W-1:0] i_raw_byte,
    input  wire t_cfg              i_cfg,
    output t_result                o_result
);

    t_phase              r_phase, n_phase;
    logic [BYTE_W-1:0]   r_len, n_len;
    logic [BYTE_W-1:0]   r_total, n_total;
    logic [BYTE_W-1:0]   r_pos, n_pos;
    logic [TICK_W-1:0]   r_ticks, n_ticks;

    logic [BYTE_W-1:0]   byte_rev;
    logic [BYTE_W-1:0]   body_len;
    logic [BYTE_W-1:0]   pos_inc;
    logic                marker_hit;
    logic                timed_out;
    logic                lcs_ok;

    assign byte_rev   = flip8(i_raw_byte);
    assign body_len   = r_len - HEADER_BYTES;
    assign pos_inc    = r_pos + 8'd1;
    assign marker_hit = (byte_rev == i_cfg.start_marker);
    assign timed_out  = (r_ticks > i_cfg.hunt_timeout);
    assign lcs_ok     = ((r_len + byte_rev) == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_len   <= '0;
            r_total <= '0;
            r_pos   <= '0;
            r_ticks <= '0;
        end else if (i_advance) begin
            r_phase <= n_phase;
            r_len   <= n_len;
            r_total <= n_total;
            r_pos   <= n_pos;
            r_ticks <= n_ticks;
        end
    end

    // next state
    always_comb begin
        n_phase = r_phase;
        n_len   = r_len;
        n_total = r_total;
        n_pos   = r_pos;
        n_ticks = r_ticks;
        if (i_req_type == REQ_START) begin
            n_phase = PH_HUNT;
            n_len   = '0;
            n_total = '0;
            n_pos   = '0;
            n_ticks = '0;
        end else if (i_req_type == REQ_TICK) begin
            if (r_phase == PH_HUNT && r_ticks != TICK_MAX) begin
                n_ticks = r_ticks + 16'd1;
            end
        end else if (i_req_type == REQ_BYTE) begin
            unique case (r_phase)
                PH_HUNT: begin
                    if (marker_hit) begin
                        n_phase = PH_LEN;
                    end else if (timed_out) begin
                        n_phase = PH_IDLE;
                    end
                end
                PH_LEN: begin
                    n_len   = byte_rev;
                    n_phase = PH_LCS;
                end
                PH_LCS: begin
                    if (!lcs_ok) begin
                        n_phase = PH_IDLE;
                    end else begin
                        n_total = (body_len > i_cfg.max_payload) ? i_cfg.max_payload
                                                                  : body_len;
                        n_pos   = '0;
                        n_phase = PH_HDR;
                    end
                end
                PH_HDR: begin
                    if (r_pos == '0) begin
                        n_pos = 8'd1;
                    end else begin
                        n_pos   = '0;
                        n_phase = (r_total == '0) ? PH_TAIL : PH_DATA;
                    end
                end
                PH_DATA: begin
                    if (pos_inc >= r_total) begin
                        n_pos   = '0;
                        n_phase = PH_TAIL;
                    end else begin
                        n_pos = pos_inc;
                    end
                end
                PH_TAIL: begin
                    if (r_pos == '0) begin
                        n_pos = 8'd1;
                    end else begin
                        n_pos   = '0;
                        n_phase = PH_IDLE;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // result
    always_comb begin
        o_result = '{kind: KIND_NONE, payload_byte: '0, payload_index: '0,
                     payload_count: '0};
        if (i_req_type == REQ_BYTE) begin
            unique case (r_phase)
                PH_HUNT: begin
                    if (!marker_hit && timed_out) begin
                        o_result.kind = KIND_TIMEOUT;
                    end
                end
                PH_LCS: begin
                    if (!lcs_ok) begin
                        o_result.kind = KIND_LCS_ERR;
                    end
                end
                PH_DATA: begin
                    o_result.kind          = KIND_BYTE;
                    o_result.payload_byte  = byte_rev;
                    o_result.payload_index = r_pos;
                end
                PH_TAIL: begin
                    if (r_pos != '0) begin
                        o_result.kind          = KIND_DONE;
                        o_result.payload_count = r_total;
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== sv/nfcrp_checker.sv =====
`default_nettype none

module nfcrp_checker
    import nfcrp_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_in_valid,
    input wire logic              i_in_ready,
    input wire logic              i_out_valid,
    input wire logic              i_out_ready,
    input wire logic [KIND_W-1:0] i_kind,
    input wire logic [BYTE_W-1:0] i_payload_byte,
    input wire logic [BYTE_W-1:0] i_payload_index,
    input wire logic [BYTE_W-1:0] i_payload_count
);

    // nothing comes out in the cycle after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // a stalled result keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_kind)
            && $stable(i_payload_byte) && $stable(i_payload_index)
            && $stable(i_payload_count))
        else $error("stalled result changed");

    // an input transfer when output is free always yields a result via the input and result registers
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && !i_out_valid |=> ##1 i_out_valid)
        else $error("accepted item produced no result");

    a_byte_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_kind != KIND_BYTE |-> i_payload_byte == '0
            && i_payload_index == '0)
        else $error("payload fields set outside a payload byte");

    a_count_field: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_kind != KIND_DONE |-> i_payload_count == '0)
        else $error("payload count set outside frame done");

endmodule

bind nfc_response_frame_parser_core nfcrp_checker u_nfcrp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_item.valid),
    .i_in_ready      (i_item.ready),
    .i_out_valid     (o_res.valid),
    .i_out_ready     (o_res.ready),
    .i_kind          (o_res.kind),
    .i_payload_byte  (o_res.payload_byte),
    .i_payload_index (o_res.payload_index),
    .i_payload_count (o_res.payload_count)
);

`default_nettype wire
